>>> hw/rtl/shbse_pkg.sv
// Package for the spherical-harmonic shading evaluator.
// Holds the request and result types, operation codes and fixed-point constants.
// No dependencies.
package shbse_pkg;

	localparam int unsigned NUM_BASIS = 25;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic REG_ORDER = 1'b0;

	localparam logic [2:0] ORDER_RESET = 3'd2;
	localparam logic [2:0] ORDER_MAX   = 3'd4;

	// 1.0 in Q30, held wide enough for the derived quadratic combinations.
	localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
	// 1.0 in Q28, the basis scale at the multiply stage.
	localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

	typedef struct packed {
		logic               operation;
		logic [4:0]         coeff_index;
		logic signed [31:0] coeff_value;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] shading;
		logic               saturated;
	} res_t;

	// Number of basis terms used for a band setting; settings above four act as four.
	function automatic logic [4:0] terms_for_order(input logic [2:0] order);
		logic [4:0] n;
		case (order)
			3'd0: n = 5'd1;
			3'd1: n = 5'd4;
			3'd2: n = 5'd9;
			3'd3: n = 5'd16;
			default: n = 5'd25;
		endcase
		return n;
	endfunction

endpackage

>>> hw/rtl/sh_basis_shading_eval.sv
// Top level of the spherical-harmonic shading evaluator.
// Depends on shbse_pkg for the request and result types and constants.
//
// Usage. Requests arrive on in_valid/in_ready/in_data. A load request
// (operation OP_LOAD) writes one Q16.16 coefficient into the coefficient
// table; indices of MAX_TERMS or more are ignored and loads give no result.
// An evaluate request (OP_EVAL) carries a Q1.15 normal and gives exactly one
// result on out_valid/out_ready/out_data: the Q16.16 dot product of the table
// with the polynomial basis, cut off after (order+1)^2 terms, rounded and
// clipped, with a flag when clipping took place.
// The pipeline has nine register stages. An evaluate request is registered in
// stages one to nine in turn before out_valid rises, and one request can be
// taken in every cycle unless an output stall has filled the pipeline. Each stage
// carries its own valid bit and holds only while the stage after it is full and
// stalled, so a stall at the output fills the empty stages first and the input
// keeps taking requests until the whole pipeline is occupied; nothing is lost
// or repeated. Loads write the table in stage six, the same stage at which
// evaluations read it, so every request sees the loads that came before it.
// The band register (harmonic_order) sits on the APB port at byte address 0
// and is meant to be changed only while the pipeline is empty.
// Reset empties the pipeline, clears the table to zero and sets the band to two.
module sh_basis_shading_eval
	import shbse_pkg::*;
#(
	parameter int unsigned MAX_TERMS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_data
);

	localparam int unsigned NGRP = (MAX_TERMS + 4) / 5;
	localparam int unsigned NSTG = 9;

	// Configuration register.
	logic [2:0] order_q;
	logic       cfg_sel;

	assign cfg_sel = (paddr[2] == REG_ORDER);
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? {29'd0, order_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (psel && penable && pwrite && cfg_sel) begin
			order_q <= pwdata[2:0];
		end
	end

	// Stage valid bits and advance enables. A stage moves when it is empty or
	// when the stage after it moves.
	logic [NSTG:1] v_q;
	logic [NSTG:1] en;

	always_comb begin
		en[NSTG] = !v_q[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = v_q[NSTG];

	// Stage one: request register.
	req_t req_s1;

	// Stage two: squares and pair products, all exact in Q30.
	logic               op_s2;
	logic [4:0]         idx_s2;
	logic signed [31:0] val_s2;
	logic signed [15:0] x_s2, y_s2, z_s2;
	logic signed [31:0] x2_s2, y2_s2, z2_s2, xy_s2, xz_s2, yz_s2;

	// Stage three: linear combinations of the quadratics.
	logic               op_s3;
	logic [4:0]         idx_s3;
	logic signed [31:0] val_s3;
	logic signed [15:0] x_s3, y_s3, z_s3;
	logic signed [31:0] x2_s3, y2_s3, z2_s3, xy_s3, xz_s3, yz_s3;
	logic signed [34:0] d_s3, a_s3, b_s3, z5m1_s3, z5m3_s3, z7m1_s3, z7m3_s3, z3m1_s3;

	// Stage four: products of degree three and four, plus the low-order terms.
	logic               op_s4;
	logic [4:0]         idx_s4;
	logic signed [31:0] val_s4;
	logic signed [35:0] lo_s4 [9];
	logic signed [31:0] z2_s4;
	logic signed [50:0] p3_s4 [7];
	logic signed [67:0] p4_s4 [7];
	logic signed [63:0] zz_s4;
	logic signed [67:0] pbx_s4, pay_s4;

	// Stage five: all basis terms in Q28.
	logic               op_s5;
	logic [4:0]         idx_s5;
	logic signed [31:0] val_s5;
	logic signed [35:0] term_s5 [NUM_BASIS];

	// Stages six to nine.
	logic signed [53:0] prod_s6 [MAX_TERMS];
	logic signed [56:0] grp_s7 [NGRP];
	logic signed [45:0] rnd_s8;
	res_t               res_s9;

	logic signed [31:0] coeff_q [MAX_TERMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= in_valid;
			if (en[2]) v_q[2] <= v_q[1];
			if (en[3]) v_q[3] <= v_q[2];
			if (en[4]) v_q[4] <= v_q[3];
			if (en[5]) v_q[5] <= v_q[4];
			// Loads end at stage five, once they have written the table.
			if (en[6]) v_q[6] <= v_q[5] && (op_s5 == OP_EVAL);
			if (en[7]) v_q[7] <= v_q[6];
			if (en[8]) v_q[8] <= v_q[7];
			if (en[9]) v_q[9] <= v_q[8];
		end
	end

	// Coefficient table, written as a load passes from stage five to six.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TERMS; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (en[6] && v_q[5] && (op_s5 == OP_LOAD)) begin
			for (int i = 0; i < MAX_TERMS; i++) begin
				if (idx_s5 == 5'(i)) coeff_q[i] <= val_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			req_s1 <= in_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			op_s2  <= req_s1.operation;
			idx_s2 <= req_s1.coeff_index;
			val_s2 <= req_s1.coeff_value;
			x_s2   <= req_s1.normal_x;
			y_s2   <= req_s1.normal_y;
			z_s2   <= req_s1.normal_z;
			x2_s2  <= req_s1.normal_x * req_s1.normal_x;
			y2_s2  <= req_s1.normal_y * req_s1.normal_y;
			z2_s2  <= req_s1.normal_z * req_s1.normal_z;
			xy_s2  <= req_s1.normal_x * req_s1.normal_y;
			xz_s2  <= req_s1.normal_x * req_s1.normal_z;
			yz_s2  <= req_s1.normal_y * req_s1.normal_z;
		end
	end

	logic signed [34:0] x2e, y2e, z2e;
	assign x2e = 35'(x2_s2);
	assign y2e = 35'(y2_s2);
	assign z2e = 35'(z2_s2);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			op_s3   <= op_s2;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			x2_s3   <= x2_s2;
			y2_s3   <= y2_s2;
			z2_s3   <= z2_s2;
			xy_s3   <= xy_s2;
			xz_s3   <= xz_s2;
			yz_s3   <= yz_s2;
			d_s3    <= x2e - y2e;
			a_s3    <= (x2e <<< 1) + x2e - y2e;
			b_s3    <= x2e - (y2e <<< 1) - y2e;
			z5m1_s3 <= (z2e <<< 2) + z2e - ONE_Q30;
			z5m3_s3 <= (z2e <<< 2) + z2e - (ONE_Q30 <<< 1) - ONE_Q30;
			z7m1_s3 <= (z2e <<< 3) - z2e - ONE_Q30;
			z7m3_s3 <= (z2e <<< 3) - z2e - (ONE_Q30 <<< 1) - ONE_Q30;
			z3m1_s3 <= (z2e <<< 1) + z2e - ONE_Q30;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			op_s4  <= op_s3;
			idx_s4 <= idx_s3;
			val_s4 <= val_s3;
			z2_s4  <= z2_s3;
			// Terms of degree up to two, taken straight to Q28.
			lo_s4[0] <= ONE_Q28;
			lo_s4[1] <= 36'(x_s3) <<< 13;
			lo_s4[2] <= 36'(y_s3) <<< 13;
			lo_s4[3] <= 36'(z_s3) <<< 13;
			lo_s4[4] <= 36'(xy_s3 >>> 2);
			lo_s4[5] <= 36'(xz_s3 >>> 2);
			lo_s4[6] <= 36'(yz_s3 >>> 2);
			lo_s4[7] <= 36'(d_s3 >>> 2);
			lo_s4[8] <= 36'(z3m1_s3 >>> 2);
			// Degree three, Q45.
			p3_s4[0] <= a_s3 * y_s3;
			p3_s4[1] <= xy_s3 * z_s3;
			p3_s4[2] <= z5m1_s3 * y_s3;
			p3_s4[3] <= z5m3_s3 * z_s3;
			p3_s4[4] <= z5m1_s3 * x_s3;
			p3_s4[5] <= d_s3 * z_s3;
			p3_s4[6] <= b_s3 * x_s3;
			// Degree four, Q60.
			p4_s4[0] <= d_s3 * xy_s3;
			p4_s4[1] <= a_s3 * yz_s3;
			p4_s4[2] <= z7m1_s3 * xy_s3;
			p4_s4[3] <= z7m3_s3 * yz_s3;
			p4_s4[4] <= z7m3_s3 * xz_s3;
			p4_s4[5] <= z7m1_s3 * d_s3;
			p4_s4[6] <= b_s3 * xz_s3;
			zz_s4  <= z2_s3 * z2_s3;
			pbx_s4 <= b_s3 * x2_s3;
			pay_s4 <= a_s3 * y2_s3;
		end
	end

	// Term twenty: 3 - 30 z^2 + 35 z^4 in Q30, with z^4 floored to Q30 first.
	logic signed [39:0] t20_w;
	logic signed [67:0] t24_w;
	assign t20_w = 40'(ONE_Q30) * 3 - 40'(z2_s4) * 30 + 40'(zz_s4 >>> 30) * 35;
	assign t24_w = pbx_s4 - pay_s4;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			op_s5  <= op_s4;
			idx_s5 <= idx_s4;
			val_s5 <= val_s4;
			for (int i = 0; i < 9; i++) begin
				term_s5[i] <= lo_s4[i];
			end
			for (int i = 0; i < 7; i++) begin
				term_s5[9 + i] <= 36'(p3_s4[i] >>> 17);
			end
			term_s5[16] <= 36'(p4_s4[0] >>> 32);
			term_s5[17] <= 36'(p4_s4[1] >>> 32);
			term_s5[18] <= 36'(p4_s4[2] >>> 32);
			term_s5[19] <= 36'(p4_s4[3] >>> 32);
			term_s5[20] <= 36'(t20_w >>> 2);
			term_s5[21] <= 36'(p4_s4[4] >>> 32);
			term_s5[22] <= 36'(p4_s4[5] >>> 32);
			term_s5[23] <= 36'(p4_s4[6] >>> 32);
			term_s5[24] <= 36'(t24_w >>> 32);
		end
	end

	// Stage six: one multiplier per term; terms above the band contribute zero.
	// The full product needs 64 bits before it is brought down to Q30.
	logic [4:0] nterms;
	assign nterms = terms_for_order(order_q);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < MAX_TERMS; i++) begin
				if (5'(i) < nterms) begin
					prod_s6[i] <= 54'((64'(coeff_q[i]) * 64'(term_s5[i])) >>> 14);
				end else begin
					prod_s6[i] <= '0;
				end
			end
		end
	end

	// Stage seven: sums over groups of five products.
	logic signed [56:0] grp_d [NGRP];
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < 5; k++) begin
				if (g * 5 + k < MAX_TERMS) begin
					grp_d[g] = grp_d[g] + 57'(prod_s6[g * 5 + k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			grp_s7 <= grp_d;
		end
	end

	// Stage eight: final sum, rounded half up from Q30 to Q16.
	logic signed [59:0] acc_d;
	always_comb begin
		acc_d = 60'sd8192;
		for (int g = 0; g < NGRP; g++) begin
			acc_d = acc_d + 60'(grp_s7[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			rnd_s8 <= 46'(acc_d >>> 14);
		end
	end

	// Stage nine: clip to the signed 32-bit range.
	localparam logic signed [45:0] SAT_HI = 46'sd2147483647;
	localparam logic signed [45:0] SAT_LO = -46'sd2147483648;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			if (rnd_s8 > SAT_HI) begin
				res_s9.shading   <= SAT_HI[31:0];
				res_s9.saturated <= 1'b1;
			end else if (rnd_s8 < SAT_LO) begin
				res_s9.shading   <= SAT_LO[31:0];
				res_s9.saturated <= 1'b1;
			end else begin
				res_s9.shading   <= rnd_s8[31:0];
				res_s9.saturated <= 1'b0;
			end
		end
	end

	assign out_data = res_s9;

endmodule
